@@ sv/zwc_pkg.sv @@
package zwc_pkg;

   localparam logic [11:0] FRAME_W = 12'd3840;
   localparam logic [11:0] FRAME_H = 12'd2160;
   localparam logic [11:0] MIN_W   = 12'd1280;

   typedef enum logic [2:0] {
      OP_SET_X       = 3'd0,
      OP_SET_Y       = 3'd1,
      OP_SET_WIDTH   = 3'd2,
      OP_CROP_LEFT   = 3'd3,
      OP_CROP_RIGHT  = 3'd4,
      OP_CROP_TOP    = 3'd5,
      OP_CROP_BOTTOM = 3'd6,
      OP_CHECK       = 3'd7
   } opcode_type;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [11:0] width;
      logic [11:0] height;
      logic [11:0] margin_left;
      logic [11:0] margin_right;
      logic [11:0] margin_top;
      logic [11:0] margin_bottom;
   } window_type;

   localparam window_type WINDOW_RESET = '{
      x:             12'd0,
      y:             12'd0,
      width:         FRAME_W,
      height:        FRAME_H,
      margin_left:   12'd0,
      margin_right:  12'd0,
      margin_top:    12'd0,
      margin_bottom: 12'd0
   };

endpackage

@@ sv/zwc_if.sv @@
interface zwc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [15:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface zwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] out_x;
   logic [11:0] out_y;
   logic [11:0] out_width;
   logic [11:0] out_height;
   logic [11:0] out_crop_left;
   logic [11:0] out_crop_right;
   logic [11:0] out_crop_top;
   logic [11:0] out_crop_bottom;
   logic        fell_back;

   modport source (
      output valid, output out_x, output out_y, output out_width, output out_height,
      output out_crop_left, output out_crop_right, output out_crop_top,
      output out_crop_bottom, output fell_back, input ready
   );
   modport sink (
      input valid, input out_x, input out_y, input out_width, input out_height,
      input out_crop_left, input out_crop_right, input out_crop_top,
      input out_crop_bottom, input fell_back, output ready
   );
endinterface

@@ sv/zwc_update.sv @@
module zwc_update (
   input  zwc_pkg::window_type cur,
   input  logic [2:0]          opcode,
   input  logic [15:0]         value,
   output zwc_pkg::window_type nxt,
   output logic                fell_back
);

   function automatic logic win_ok(input zwc_pkg::window_type s);
      logic [12:0] right_edge;
      logic [12:0] bottom_edge;
      right_edge  = {1'b0, s.x} + {1'b0, s.width};
      bottom_edge = {1'b0, s.y} + {1'b0, s.height};
      return (s.x < zwc_pkg::FRAME_W) && (s.y < zwc_pkg::FRAME_H) &&
             (right_edge <= {1'b0, zwc_pkg::FRAME_W}) &&
             (bottom_edge <= {1'b0, zwc_pkg::FRAME_H}) &&
             (s.width != 12'd0) && (s.height != 12'd0);
   endfunction

   logic [11:0]         clamp_w;
   logic [11:0]         clamp_h;
   logic [11:0]         new_w;
   logic [15:0]         w_times9;
   logic [11:0]         new_h;
   logic [12:0]         mid_x;
   logic [12:0]         mid_y;
   logic [12:0]         half_w;
   logic [12:0]         half_h;
   logic [12:0]         diff_x;
   logic [12:0]         diff_y;
   zwc_pkg::window_type cand_x;
   zwc_pkg::window_type cand_y;
   zwc_pkg::window_type cand_w;
   zwc_pkg::window_type upd;

   always_comb begin
      clamp_w = (value > {4'd0, zwc_pkg::FRAME_W}) ? zwc_pkg::FRAME_W : value[11:0];
      clamp_h = (value > {4'd0, zwc_pkg::FRAME_H}) ? zwc_pkg::FRAME_H : value[11:0];
      new_w   = (clamp_w < zwc_pkg::MIN_W) ? zwc_pkg::MIN_W : clamp_w;
      // 2160/3840 is 9/16
      w_times9 = {1'b0, new_w, 3'd0} + {4'd0, new_w};
      new_h    = w_times9[15:4];

      mid_x  = {1'b0, cur.x} + {2'd0, cur.width[11:1]};
      mid_y  = {1'b0, cur.y} + {2'd0, cur.height[11:1]};
      half_w = {2'd0, new_w[11:1]};
      half_h = {2'd0, new_h[11:1]};
      diff_x = mid_x - half_w;
      diff_y = mid_y - half_h;

      cand_x   = cur;
      cand_x.x = clamp_w;
      if (!win_ok(cand_x)) begin
         cand_x.x = zwc_pkg::FRAME_W - cur.width;
      end

      cand_y   = cur;
      cand_y.y = clamp_h;
      if (!win_ok(cand_y)) begin
         cand_y.y = zwc_pkg::FRAME_H - cur.height;
      end

      cand_w        = cur;
      cand_w.width  = new_w;
      cand_w.height = new_h;
      cand_w.x      = (mid_x > half_w) ? diff_x[11:0] : 12'd0;
      cand_w.y      = (mid_y > half_h) ? diff_y[11:0] : 12'd0;
      if (!win_ok(cand_w)) begin
         cand_w.x = zwc_pkg::FRAME_W - new_w;
         cand_w.y = zwc_pkg::FRAME_H - new_h;
      end

      upd = cur;
      unique case (zwc_pkg::opcode_type'(opcode))
         zwc_pkg::OP_SET_X:       upd = cand_x;
         zwc_pkg::OP_SET_Y:       upd = cand_y;
         zwc_pkg::OP_SET_WIDTH:   upd = cand_w;
         zwc_pkg::OP_CROP_LEFT:   upd.margin_left   = clamp_w;
         zwc_pkg::OP_CROP_RIGHT:  upd.margin_right  = clamp_w;
         zwc_pkg::OP_CROP_TOP:    upd.margin_top    = clamp_h;
         zwc_pkg::OP_CROP_BOTTOM: upd.margin_bottom = clamp_h;
         zwc_pkg::OP_CHECK:       upd = cur;
      endcase

      if (win_ok(upd)) begin
         nxt       = upd;
         fell_back = 1'b0;
      end else begin
         nxt       = zwc_pkg::WINDOW_RESET;
         fell_back = 1'b1;
      end
   end

endmodule

@@ sv/zoom_window_controller.sv @@
// Pan/zoom window controller over a 3840x2160 frame. Each request item carries one
// command (set x, set y, set width, set one crop margin, or check only) and gives
// exactly one response item with the full window and margins after the update, plus
// fell_back when the window had to return to full frame. One item is taken every
// clock while the response side is not stalled; a request passes through the request
// register, then the result register, and the window state is updated in the same cycle
// that loads the result, so consecutive commands see each other's effect. A stalled
// response holds its item while one more request waits in the request register.
module zoom_window_controller (
   input logic       clock,
   input logic       reset,
   zwc_req_if.sink   req_chan,
   zwc_rsp_if.source rsp_chan
);

   logic                in_valid_ff;
   logic [2:0]          opcode_ff;
   logic [15:0]         value_ff;
   zwc_pkg::window_type win_ff;
   zwc_pkg::window_type win_in;
   zwc_pkg::window_type out_ff;
   logic                fell_back_ff;
   logic                fell_back_in;
   logic                out_valid_ff;
   logic                advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   zwc_update u_update (
      .cur       (win_ff),
      .opcode    (opcode_ff),
      .value     (value_ff),
      .nxt       (win_in),
      .fell_back (fell_back_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         win_ff       <= zwc_pkg::WINDOW_RESET;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            win_ff       <= win_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         opcode_ff <= req_chan.opcode;
         value_ff  <= req_chan.value;
      end
      if (advance) begin
         out_ff       <= win_in;
         fell_back_ff <= fell_back_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.out_x           = out_ff.x;
   assign rsp_chan.out_y           = out_ff.y;
   assign rsp_chan.out_width       = out_ff.width;
   assign rsp_chan.out_height      = out_ff.height;
   assign rsp_chan.out_crop_left   = out_ff.margin_left;
   assign rsp_chan.out_crop_right  = out_ff.margin_right;
   assign rsp_chan.out_crop_top    = out_ff.margin_top;
   assign rsp_chan.out_crop_bottom = out_ff.margin_bottom;
   assign rsp_chan.fell_back       = fell_back_ff;

endmodule

@@ bench/tb_zoom_window_controller.sv @@
`timescale 1ns / 100ps

module tb_zoom_window_controller;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PACE = 350;
   localparam int MAX_REPORTS = 10;

   typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   typedef struct {
      zwc_pkg::opcode_type op;
      logic [15:0]         value;
      pace_type            pace;
   } command_type;

   typedef struct packed {
      zwc_pkg::window_type win;
      logic                fell_back;
   } zoom_result_type;

   typedef int unsigned field_set_type [9];

   logic clock;
   logic reset;

   zwc_req_if req_chan ();
   zwc_rsp_if rsp_chan ();

   zoom_window_controller u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   command_type         command_queue[$];
   zoom_result_type     expected_windows[$];
   zwc_pkg::window_type model_window;
   command_type         next_command;
   pace_type            active_pace;
   int                  error_count;
   int                  cycle_count;

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      return (v > hi) ? hi : v;
   endfunction

   function automatic bit window_fits(zwc_pkg::window_type w);
      int unsigned x, y, wd, ht;
      x  = w.x;
      y  = w.y;
      wd = w.width;
      ht = w.height;
      return (x < zwc_pkg::FRAME_W) && (y < zwc_pkg::FRAME_H) &&
             (x + wd <= zwc_pkg::FRAME_W) && (y + ht <= zwc_pkg::FRAME_H) &&
             (wd != 0) && (ht != 0);
   endfunction

   function automatic zoom_result_type apply_command(zwc_pkg::opcode_type op,
                                                     logic [15:0] value);
      int unsigned v, w, h, mid_x, mid_y;
      zoom_result_type r;
      v = value;
      r.fell_back = 1'b0;
      case (op)
         zwc_pkg::OP_SET_X: begin
            model_window.x = 12'(clamp_to(v, zwc_pkg::FRAME_W));
            if (!window_fits(model_window))
               model_window.x = zwc_pkg::FRAME_W - model_window.width;
         end
         zwc_pkg::OP_SET_Y: begin
            model_window.y = 12'(clamp_to(v, zwc_pkg::FRAME_H));
            if (!window_fits(model_window))
               model_window.y = zwc_pkg::FRAME_H - model_window.height;
         end
         zwc_pkg::OP_SET_WIDTH: begin
            mid_x = 32'(model_window.x) + 32'(model_window.width) / 2;
            mid_y = 32'(model_window.y) + 32'(model_window.height) / 2;
            w = clamp_to(v, zwc_pkg::FRAME_W);
            if (w < zwc_pkg::MIN_W)
               w = zwc_pkg::MIN_W;
            h = (32'(zwc_pkg::FRAME_H) * w) / 32'(zwc_pkg::FRAME_W);
            model_window.width  = 12'(w);
            model_window.height = 12'(h);
            model_window.x = (mid_x > w / 2) ? 12'(mid_x - w / 2) : 12'd0;
            model_window.y = (mid_y > h / 2) ? 12'(mid_y - h / 2) : 12'd0;
            if (!window_fits(model_window)) begin
               model_window.x = zwc_pkg::FRAME_W - model_window.width;
               model_window.y = zwc_pkg::FRAME_H - model_window.height;
            end
         end
         zwc_pkg::OP_CROP_LEFT:
            model_window.margin_left   = 12'(clamp_to(v, zwc_pkg::FRAME_W));
         zwc_pkg::OP_CROP_RIGHT:
            model_window.margin_right  = 12'(clamp_to(v, zwc_pkg::FRAME_W));
         zwc_pkg::OP_CROP_TOP:
            model_window.margin_top    = 12'(clamp_to(v, zwc_pkg::FRAME_H));
         zwc_pkg::OP_CROP_BOTTOM:
            model_window.margin_bottom = 12'(clamp_to(v, zwc_pkg::FRAME_H));
         default: ;
      endcase
      if (!window_fits(model_window)) begin
         model_window = zwc_pkg::WINDOW_RESET;
         r.fell_back = 1'b1;
      end
      r.win = model_window;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   function automatic field_set_type fields_of(zoom_result_type r);
      field_set_type f;
      f[0] = r.win.x;
      f[1] = r.win.y;
      f[2] = r.win.width;
      f[3] = r.win.height;
      f[4] = r.win.margin_left;
      f[5] = r.win.margin_right;
      f[6] = r.win.margin_top;
      f[7] = r.win.margin_bottom;
      f[8] = r.fell_back;
      return f;
   endfunction

   function automatic string describe(zoom_result_type r);
      return $sformatf("x=%0d y=%0d w=%0d h=%0d crop l/r/t/b=%0d/%0d/%0d/%0d fb=%0d",
                       r.win.x, r.win.y, r.win.width, r.win.height, r.win.margin_left,
                       r.win.margin_right, r.win.margin_top, r.win.margin_bottom,
                       r.fell_back);
   endfunction

   task automatic check_window();
      zoom_result_type want, got;
      field_set_type   want_f, got_f;
      bit              bad;
      got.win = '{x: rsp_chan.out_x, y: rsp_chan.out_y, width: rsp_chan.out_width,
                  height: rsp_chan.out_height, margin_left: rsp_chan.out_crop_left,
                  margin_right: rsp_chan.out_crop_right,
                  margin_top: rsp_chan.out_crop_top,
                  margin_bottom: rsp_chan.out_crop_bottom};
      got.fell_back = rsp_chan.fell_back;
      if (expected_windows.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: response item with no command outstanding: %s", $realtime,
                     describe(got));
         return;
      end
      want = expected_windows.pop_front();
      want_f = fields_of(want);
      got_f = fields_of(got);
      bad = 1'b0;
      for (int i = 0; i < 9; i++)
         if (want_f[i] != got_f[i])
            bad = 1'b1;
      if (bad) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t: window mismatch", $realtime);
            $display("   expected %s", describe(want));
            $display("   actual   %s", describe(got));
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic bit sender_idles(pace_type p);
      case (p)
         PACE_SEND_IDLE: return $urandom_range(0, 99) < 60;
         PACE_BOTH:      return $urandom_range(0, 99) < 18;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_ready(pace_type p);
      case (p)
         PACE_RECV_STALL: return $urandom_range(0, 99) >= 60;
         PACE_BOTH:       return $urandom_range(0, 99) >= 18;
         default:         return 1'b1;
      endcase
   endfunction

   function automatic logic [15:0] pick_value();
      int unsigned edges [12];
      edges = '{0, 1, 640, 1279, 1280, 1281, 1920, 2159, 2160, 2161, 3839, 3840};
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 4095));
         2: return 16'($urandom_range(0, 3840));
         // near the clamp limits; zero minus one wraps to all-ones
         default: return 16'(edges[$urandom_range(0, 11)] + $urandom_range(0, 2) - 1);
      endcase
   endfunction

   task automatic add_command(zwc_pkg::opcode_type op, int unsigned value, pace_type pace);
      command_queue.push_back('{op: op, value: 16'(value), pace: pace});
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_windows.push_back(
               apply_command(zwc_pkg::opcode_type'(req_chan.opcode), req_chan.value));
         if (!req_chan.valid || req_chan.ready) begin
            if (command_queue.size() != 0 && !sender_idles(command_queue[0].pace)) begin
               next_command = command_queue.pop_front();
               req_chan.valid  <= 1'b1;
               req_chan.opcode <= next_command.op;
               req_chan.value  <= next_command.value;
               active_pace     <= next_command.pace;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_window();
         rsp_chan.ready <= receiver_ready(active_pace);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.opcode = zwc_pkg::OP_CHECK;
      req_chan.value  = '0;
      rsp_chan.ready  = 1'b0;
      model_window = zwc_pkg::WINDOW_RESET;
      active_pace = PACE_FULL;
      error_count = 0;
      cycle_count = 0;

      // directed: clamps, push-back against the edges, width limits, all-ones values
      add_command(zwc_pkg::OP_CHECK,       0,     PACE_FULL);
      add_command(zwc_pkg::OP_SET_X,       65535, PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   0,     PACE_FULL);
      add_command(zwc_pkg::OP_SET_X,       3840,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_X,       0,     PACE_FULL);
      add_command(zwc_pkg::OP_SET_Y,       65535, PACE_FULL);
      add_command(zwc_pkg::OP_SET_Y,       0,     PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   1279,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_X,       4095,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_Y,       2159,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   1281,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   3839,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   1280,  PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   65535, PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   2000,  PACE_FULL);
      add_command(zwc_pkg::OP_CROP_LEFT,   65535, PACE_FULL);
      add_command(zwc_pkg::OP_CROP_LEFT,   3841,  PACE_FULL);
      add_command(zwc_pkg::OP_CROP_RIGHT,  3840,  PACE_FULL);
      add_command(zwc_pkg::OP_CROP_RIGHT,  0,     PACE_FULL);
      add_command(zwc_pkg::OP_CROP_TOP,    2161,  PACE_FULL);
      add_command(zwc_pkg::OP_CROP_TOP,    2160,  PACE_FULL);
      add_command(zwc_pkg::OP_CROP_BOTTOM, 65535, PACE_FULL);
      add_command(zwc_pkg::OP_SET_WIDTH,   3841,  PACE_FULL);
      add_command(zwc_pkg::OP_CHECK,       65535, PACE_FULL);

      for (int p = PACE_FULL; p <= PACE_BOTH; p++)
         for (int i = 0; i < ITEMS_PER_PACE; i++)
            add_command(zwc_pkg::opcode_type'($urandom_range(0, 7)), pick_value(),
                        pace_type'(p));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0 || req_chan.valid || expected_windows.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && expected_windows.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
